// File: rtl/shrc_pkg.sv
// shared types, register indexes and band constants of the staged heater relay control
`default_nettype none

package shrc_pkg;

   localparam int unsigned HourWidth  = 5;
   localparam int unsigned TempWidth  = 8;
   localparam int unsigned GapWidth   = 10;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 8;

   // run modes
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_THERMO = 2'd1;
   localparam logic [1:0] MODE_SCHED  = 2'd2;
   localparam logic [1:0] MODE_WIDE   = 2'd3;

   // register indexes
   localparam logic [CsrAddrWidth-1:0] REG_HEAT_MODE   = 3'd0;
   localparam logic [CsrAddrWidth-1:0] REG_TARGET_TEMP = 3'd1;
   localparam logic [CsrAddrWidth-1:0] REG_WIN1_START  = 3'd2;
   localparam logic [CsrAddrWidth-1:0] REG_WIN1_STOP   = 3'd3;
   localparam logic [CsrAddrWidth-1:0] REG_WIN2_START  = 3'd4;
   localparam logic [CsrAddrWidth-1:0] REG_WIN2_STOP   = 3'd5;
   localparam logic [CsrAddrWidth-1:0] REG_WIN3_START  = 3'd6;
   localparam logic [CsrAddrWidth-1:0] REG_WIN3_STOP   = 3'd7;

   // gap band edges and limits
   localparam logic signed [GapWidth-1:0] BAND_5  = 10'sd5;
   localparam logic signed [GapWidth-1:0] BAND_10 = 10'sd10;
   localparam logic signed [GapWidth-1:0] BAND_15 = 10'sd15;
   localparam logic signed [GapWidth-1:0] BAND_20 = 10'sd20;
   localparam logic [TempWidth-1:0]       TARGET_MAX = 8'd80;

   localparam logic [3:0] POWER_NONE = 4'd0;
   localparam logic [3:0] POWER_LOW  = 4'd2;
   localparam logic [3:0] POWER_MID  = 4'd5;
   localparam logic [3:0] POWER_HIGH = 4'd8;

   typedef struct packed {
      logic [1:0]           heat_mode;
      logic [TempWidth-1:0] target_temp;
      logic [HourWidth-1:0] win1_start;
      logic [HourWidth-1:0] win1_stop;
      logic [HourWidth-1:0] win2_start;
      logic [HourWidth-1:0] win2_stop;
      logic [HourWidth-1:0] win3_start;
      logic [HourWidth-1:0] win3_stop;
   } shrc_cfg_type;

   // laid out so that the lowest bit is main_relay, as on the result bus
   typedef struct packed {
      logic [1:0] ready_window;
      logic       fan_on;
      logic [3:0] power_level;
      logic       heating;
      logic       keep_warm;
      logic [2:0] relays;      // bit0 low, bit1 mid, bit2 high
      logic       main_relay;
   } shrc_state_type;

   localparam int unsigned StateWidth = $bits(shrc_state_type);
   localparam int unsigned RspDataWidth = ((StateWidth + 7) / 8) * 8;
   localparam int unsigned ReqDataWidth = ((HourWidth + TempWidth + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: rtl/shrc_core.sv
// next relay and status state for one control tick
`default_nettype none

module shrc_core
   import shrc_pkg::*;
(
   input  shrc_cfg_type          cfg,
   input  shrc_state_type        state_cur,
   input  logic [HourWidth-1:0]  hour_now,
   input  logic [TempWidth-1:0]  measured_temp,
   output shrc_state_type        state_next
);

   logic signed [GapWidth-1:0] gap;
   logic signed [GapWidth-1:0] band_a;
   logic signed [GapWidth-1:0] band_b;
   logic signed [GapWidth-1:0] band_c;
   logic                       in_low;
   logic                       in_mid;
   logic                       in_high;
   logic                       off_rule;
   logic [2:0]                 work;
   logic [2:0]                 ready;
   logic [HourWidth-1:0]       win_s [3];
   logic [HourWidth-1:0]       win_e [3];
   logic [HourWidth-1:0]       win_p [3];
   logic [HourWidth-1:0]       win_end [3];
   logic [1:0]                 idx;
   logic                       reached;

   assign gap = $signed({2'b00, cfg.target_temp})
              - $signed({{(GapWidth-TempWidth){measured_temp[TempWidth-1]}}, measured_temp});

   always_comb begin
      if (cfg.heat_mode == MODE_WIDE) begin
         band_a = BAND_10;
         band_b = BAND_15;
         band_c = BAND_20;
      end else begin
         band_a = BAND_5;
         band_b = BAND_10;
         band_c = BAND_15;
      end
   end

   assign in_low   = (gap >= band_a) && (gap <= band_b);
   assign in_mid   = (gap > band_b) && (gap <= band_c);
   assign in_high  = gap > band_c;
   assign off_rule = (gap <= 10'sd0) || (cfg.target_temp > TARGET_MAX);

   assign win_s[0] = cfg.win1_start;
   assign win_e[0] = cfg.win1_stop;
   assign win_p[0] = cfg.win3_stop;
   assign win_s[1] = cfg.win2_start;
   assign win_e[1] = cfg.win2_stop;
   assign win_p[1] = cfg.win1_stop;
   assign win_s[2] = cfg.win3_start;
   assign win_e[2] = cfg.win3_stop;
   assign win_p[2] = cfg.win2_stop;

   // window active and ready tests, both wrap past midnight
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (win_e[k] < win_s[k]) begin
            work[k]    = !((hour_now >= win_e[k]) && (hour_now < win_s[k]));
            win_end[k] = win_s[k];
         end else begin
            work[k]    = (hour_now >= win_s[k]) && (hour_now < win_e[k]);
            win_end[k] = win_e[k];
         end
         if (win_end[k] < win_p[k]) begin
            ready[k] = !((hour_now >= win_end[k]) && (hour_now < win_p[k]));
         end else begin
            ready[k] = (hour_now >= win_p[k]) && (hour_now < win_end[k]);
         end
      end
   end

   // windows tested in order, stopping at the first active one
   always_comb begin
      idx     = state_cur.ready_window;
      reached = 1'b1;
      for (int k = 0; k < 3; k++) begin
         if (reached && ready[k]) begin
            idx = 2'(k + 1);
         end
         reached = reached && !work[k];
      end
   end

   always_comb begin
      state_next = state_cur;
      case (cfg.heat_mode)
         MODE_OFF: begin
            state_next.main_relay = 1'b0;
            state_next.relays     = 3'b000;
         end
         MODE_THERMO, MODE_WIDE, MODE_SCHED: begin
            state_next.main_relay = 1'b1;
            if (cfg.heat_mode == MODE_SCHED) begin
               state_next.ready_window = idx;
            end
            if ((cfg.heat_mode == MODE_SCHED) ? (work == 3'b000) : off_rule) begin
               state_next.relays      = 3'b000;
               state_next.keep_warm   = 1'b1;
               state_next.heating     = 1'b0;
               state_next.power_level = POWER_NONE;
               state_next.fan_on      = 1'b1;
            end else if (in_low) begin
               state_next.relays[0]   = 1'b1;
               state_next.keep_warm   = 1'b1;
               state_next.heating     = 1'b0;
               state_next.power_level = POWER_LOW;
               state_next.fan_on      = 1'b1;
            end else if (in_mid) begin
               state_next.relays[1]   = 1'b1;
               state_next.keep_warm   = 1'b0;
               state_next.heating     = 1'b1;
               state_next.power_level = POWER_MID;
               state_next.fan_on      = 1'b1;
            end else if (in_high) begin
               state_next.relays[2]   = 1'b1;
               state_next.keep_warm   = 1'b0;
               state_next.heating     = 1'b1;
               state_next.power_level = POWER_HIGH;
               state_next.fan_on      = 1'b1;
            end
         end
         default: begin
            state_next = state_cur;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/staged_heater_relay_control.sv
// top level of the staged heater relay control: registers, state update and result buffer
//
//   channel | dir | handshake              | content
//   req     | in  | req_tvalid/req_tready  | hour_now, measured_temp
//   rsp     | out | rsp_tvalid/rsp_tready  | relays, status, power, ready window
//   csr     | in  | csr_we                 | run mode, target, window hours
//
// one tick per cycle while req_tready is high: the relay state is updated by a single
// level of compare logic at the req transfer and the result is registered for rsp.
// a two-entry result buffer (output register plus skid) keeps req open while rsp stalls;
// req_tready drops only when both entries hold results.
// reset clears registers, relay state and the buffer.
`default_nettype none

module staged_heater_relay_control
   import shrc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [4:0] hour_now, [12:5] measured_temp, [15:13] zero
   input  logic [ReqDataWidth-1:0]  req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] main_relay, [1] relay_low, [2] relay_mid, [3] relay_high, [4] keep_warm,
   // [5] heating, [9:6] power_level, [10] fan_on, [12:11] ready_window, [15:13] zero
   output logic [RspDataWidth-1:0]  rsp_tdata,
   input  logic                     csr_we,
   input  logic [CsrAddrWidth-1:0]  csr_addr,
   input  logic [CsrDataWidth-1:0]  csr_wdata
);

   shrc_cfg_type   cfg_ff;
   shrc_state_type state_ff;
   shrc_state_type state_in;
   shrc_state_type rsp_data_ff;
   shrc_state_type rsp_data_in;
   shrc_state_type skid_data_ff;
   shrc_state_type skid_data_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           skid_valid_ff;
   logic           skid_valid_in;
   logic           req_fire;
   logic           rsp_fire;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_fire   = rsp_valid_ff && rsp_tready;
   assign rsp_tdata  = {{(RspDataWidth-StateWidth){1'b0}}, rsp_data_ff};

   shrc_core u_core (
      .cfg           (cfg_ff),
      .state_cur     (state_ff),
      .hour_now      (req_tdata[HourWidth-1:0]),
      .measured_temp (req_tdata[HourWidth+TempWidth-1:HourWidth]),
      .state_next    (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_HEAT_MODE:   cfg_ff.heat_mode   <= csr_wdata[1:0];
            REG_TARGET_TEMP: cfg_ff.target_temp <= csr_wdata[TempWidth-1:0];
            REG_WIN1_START:  cfg_ff.win1_start  <= csr_wdata[HourWidth-1:0];
            REG_WIN1_STOP:   cfg_ff.win1_stop   <= csr_wdata[HourWidth-1:0];
            REG_WIN2_START:  cfg_ff.win2_start  <= csr_wdata[HourWidth-1:0];
            REG_WIN2_STOP:   cfg_ff.win2_stop   <= csr_wdata[HourWidth-1:0];
            REG_WIN3_START:  cfg_ff.win3_start  <= csr_wdata[HourWidth-1:0];
            REG_WIN3_STOP:   cfg_ff.win3_stop   <= csr_wdata[HourWidth-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // result buffer: skid drains into the output register first
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_fire) begin
         rsp_valid_in  = skid_valid_ff;
         rsp_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (req_fire) begin
         if (!rsp_valid_in) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = state_in;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // skid never holds a result ahead of an empty output register
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid while output register empty");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("transfer during stall not held in skid");

   a_off_opens_all: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cfg_ff.heat_mode == MODE_OFF) |=>
         (state_ff.relays == 3'b000 && !state_ff.main_relay))
      else $error("off mode left a relay closed");

   a_window_only_sched: assert property (@(posedge clock) disable iff (reset)
      (req_fire && cfg_ff.heat_mode != MODE_SCHED) |=>
         (state_ff.ready_window == $past(state_ff.ready_window)))
      else $error("ready window changed outside scheduled mode");

   a_power_levels: assert property (@(posedge clock) disable iff (reset)
      (state_ff.power_level == POWER_NONE) || (state_ff.power_level == POWER_LOW) ||
      (state_ff.power_level == POWER_MID) || (state_ff.power_level == POWER_HIGH))
      else $error("power level outside the reported set");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for the staged heater relay control: random and directed ticks
`timescale 1ns / 1ps

module tb_top
   import shrc_pkg::*;
();

   localparam int WatchdogLimit = 2000;
   localparam int RandomPhases  = 20;
   localparam int PhaseTicks    = 25;

   class heater_scoreboard;
      logic [1:0]           heat_mode;
      logic [TempWidth-1:0] target;
      logic [HourWidth-1:0] win_hour[6];
      shrc_state_type       relay_state;
      shrc_state_type       expected_states[$];
      int                   mismatches;
      int                   checked;

      function new();
         heat_mode   = MODE_OFF;
         target      = '0;
         foreach (win_hour[i]) win_hour[i] = '0;
         relay_state = '0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void write_reg(logic [CsrAddrWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
         case (idx)
            REG_HEAT_MODE:   heat_mode = val[1:0];
            REG_TARGET_TEMP: target = val;
            default:         win_hour[int'(idx) - int'(REG_WIN1_START)] = val[HourWidth-1:0];
         endcase
      endfunction

      function void set_status(bit keep, bit heat, logic [3:0] power);
         relay_state.keep_warm   = keep;
         relay_state.heating     = heat;
         relay_state.fan_on      = 1'b1;
         relay_state.power_level = power;
      endfunction

      function void heat_bands(int gap, int lo, int mid, int hi);
         if (gap >= lo && gap <= mid) begin
            relay_state.relays[0] = 1'b1;
            set_status(1'b1, 1'b0, POWER_LOW);
         end
         if (gap > mid && gap <= hi) begin
            relay_state.relays[1] = 1'b1;
            set_status(1'b0, 1'b1, POWER_MID);
         end
         if (gap > hi) begin
            relay_state.relays[2] = 1'b1;
            set_status(1'b0, 1'b1, POWER_HIGH);
         end
      endfunction

      function void stages_off();
         relay_state.relays = '0;
         set_status(1'b1, 1'b0, POWER_NONE);
      endfunction

      // a window with stop before start wraps past midnight
      function void window_test(int h, int s, int e, int p, output bit active,
                                output bit ready);
         int edge_hour;
         edge_hour = e;
         if (e < s) begin
            active    = !(h >= e && h < s);
            edge_hour = s;
         end else begin
            active = (h >= s && h < e);
         end
         if (edge_hour < p) ready = !(h >= edge_hour && h < p);
         else ready = (h >= p && h < edge_hour);
      endfunction

      // state after one tick, queued as the expected result
      function void next_relay_state(logic [HourWidth-1:0] hour,
                                     logic signed [TempWidth-1:0] temp);
         int gap;
         int prev;
         bit active;
         bit ready;
         gap    = int'(target) - int'(temp);
         active = 0;
         ready  = 0;
         case (heat_mode)
            MODE_OFF: begin
               relay_state.main_relay = 1'b0;
               relay_state.relays     = '0;
            end
            MODE_THERMO, MODE_WIDE: begin
               relay_state.main_relay = 1'b1;
               if (heat_mode == MODE_THERMO)
                  heat_bands(gap, int'(BAND_5), int'(BAND_10), int'(BAND_15));
               else
                  heat_bands(gap, int'(BAND_10), int'(BAND_15), int'(BAND_20));
               if (gap <= 0 || target > TARGET_MAX) stages_off();
            end
            default: begin
               relay_state.main_relay = 1'b1;
               for (int k = 0; k < 3; k++) begin
                  prev = int'(win_hour[k == 0 ? 5 : 2 * k - 1]);
                  window_test(int'(hour), int'(win_hour[2 * k]), int'(win_hour[2 * k + 1]),
                              prev, active, ready);
                  if (ready) relay_state.ready_window = 2'(k + 1);
                  if (active) break;
               end
               if (active) heat_bands(gap, int'(BAND_5), int'(BAND_10), int'(BAND_15));
               else stages_off();
            end
         endcase
         expected_states.push_back(relay_state);
      endfunction

      function void compare_field(string name, int exp_val, int act_val);
         if (exp_val != act_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      function void check_response(logic [RspDataWidth-1:0] data);
         shrc_state_type exp_st;
         shrc_state_type act_st;
         if (expected_states.size() == 0) begin
            $error("result transfer with no expected state waiting");
            mismatches++;
            return;
         end
         exp_st = expected_states.pop_front();
         act_st = shrc_state_type'(data[StateWidth-1:0]);
         checked++;
         compare_field("main_relay", int'(exp_st.main_relay), int'(act_st.main_relay));
         compare_field("relay_low", int'(exp_st.relays[0]), int'(act_st.relays[0]));
         compare_field("relay_mid", int'(exp_st.relays[1]), int'(act_st.relays[1]));
         compare_field("relay_high", int'(exp_st.relays[2]), int'(act_st.relays[2]));
         compare_field("keep_warm", int'(exp_st.keep_warm), int'(act_st.keep_warm));
         compare_field("heating", int'(exp_st.heating), int'(act_st.heating));
         compare_field("power_level", int'(exp_st.power_level), int'(act_st.power_level));
         compare_field("fan_on", int'(exp_st.fan_on), int'(act_st.fan_on));
         compare_field("ready_window", int'(exp_st.ready_window),
                       int'(act_st.ready_window));
      endfunction

      function int pending();
         return expected_states.size();
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_we;
   logic [CsrAddrWidth-1:0] csr_addr;
   logic [CsrDataWidth-1:0] csr_wdata;

   heater_scoreboard sb = new();
   bit               no_idle;
   int               ticks_sent;
   int               settings_used;
   int               idle_cycles;

   staged_heater_relay_control i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // temperatures mostly close to the target so the bands get hit
   function automatic logic [TempWidth-1:0] pick_temp(int tgt);
      int v;
      v = tgt - (int'($urandom_range(0, 40)) - 8);
      if ($urandom_range(0, 3) == 0 || v > 127 || v < -128) v = $urandom;
      return v[TempWidth-1:0];
   endfunction

   // monitor: sample transfers at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (req_tvalid && req_tready) begin
            sb.next_relay_state(req_tdata[HourWidth-1:0],
                                req_tdata[HourWidth+TempWidth-1:HourWidth]);
            ticks_sent++;
         end
         if (csr_we) sb.write_reg(csr_addr, csr_wdata);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("timeout: no transfer for %0d cycles", idle_cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side back-pressure
   initial begin : rsp_stall
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0 && !no_idle) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   task automatic send_tick(logic [HourWidth-1:0] hour, logic [TempWidth-1:0] temp);
      int gap;
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = '0;
      req_tdata[HourWidth-1:0] = hour;
      req_tdata[HourWidth+TempWidth-1:HourWidth] = temp;
      do @(posedge clock); while (!req_tready);
      gap = no_idle ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // hold the sender until every expected state has come back
   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [CsrAddrWidth-1:0] idx, int val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = idx;
      csr_wdata = val[CsrDataWidth-1:0];
   endtask

   task automatic set_config(logic [1:0] mode, int tgt, int w1s, int w1e, int w2s, int w2e,
                             int w3s, int w3e);
      drain();
      csr_write(REG_HEAT_MODE, int'(mode));
      csr_write(REG_TARGET_TEMP, tgt);
      csr_write(REG_WIN1_START, w1s);
      csr_write(REG_WIN1_STOP, w1e);
      csr_write(REG_WIN2_START, w2s);
      csr_write(REG_WIN2_STOP, w2e);
      csr_write(REG_WIN3_START, w3s);
      csr_write(REG_WIN3_STOP, w3e);
      @(negedge clock);
      csr_we = 1'b0;
      settings_used++;
   endtask

   task automatic run_directed();
      // thermostat: band edges, small gap, zero and negative gap, extremes
      set_config(MODE_THERMO, 20, 0, 0, 0, 0, 0, 0);
      send_tick(5'd3, 8'd16);
      send_tick(5'd3, 8'd15);
      send_tick(5'd3, 8'd10);
      send_tick(5'd3, 8'd9);
      send_tick(5'd3, 8'd5);
      send_tick(5'd3, 8'd4);
      send_tick(5'd3, 8'd20);
      send_tick(5'd3, 8'd127);
      send_tick(5'd3, 8'h80);
      // wide bands at the target limit
      set_config(MODE_WIDE, 80, 0, 0, 0, 0, 0, 0);
      send_tick(5'd0, 8'd70);
      send_tick(5'd0, 8'd65);
      send_tick(5'd0, 8'd60);
      send_tick(5'd0, 8'd59);
      send_tick(5'd0, 8'd75);
      set_config(MODE_WIDE, 81, 0, 0, 0, 0, 0, 0);
      send_tick(5'd0, 8'd0);
      set_config(MODE_WIDE, 255, 0, 0, 0, 0, 0, 0);
      send_tick(5'd31, 8'h80);
      // schedule with a window across midnight and hours past 23
      set_config(MODE_SCHED, 30, 22, 6, 8, 12, 17, 20);
      send_tick(5'd0, 8'd25);
      send_tick(5'd7, 8'd10);
      send_tick(5'd10, 8'd18);
      send_tick(5'd13, 8'd0);
      send_tick(5'd18, 8'h80);
      send_tick(5'd23, 8'd24);
      send_tick(5'd31, 8'd10);
      set_config(MODE_OFF, 30, 22, 6, 8, 12, 17, 20);
      send_tick(5'd5, 8'd0);
   endtask

   task automatic run_random();
      int tgt;
      int w[6];
      logic [HourWidth-1:0] hour;
      for (int ph = 0; ph < RandomPhases; ph++) begin
         case ($urandom_range(0, 7))
            0:       tgt = 0;
            1:       tgt = 80;
            2:       tgt = 81;
            3:       tgt = 255;
            default: tgt = $urandom_range(0, 120);
         endcase
         foreach (w[i]) w[i] = $urandom_range(0, 23);
         if (ph == 1) foreach (w[i]) w[i] = 23;
         set_config(2'($urandom_range(0, 3)), tgt, w[0], w[1], w[2], w[3], w[4], w[5]);
         no_idle = (ph % 5 == 0);
         for (int n = 0; n < PhaseTicks; n++) begin
            hour = HourWidth'(($urandom_range(0, 7) == 0) ? $urandom_range(24, 31)
                                                           : $urandom_range(0, 23));
            send_tick(hour, pick_temp(tgt));
            if ($urandom_range(0, 39) == 0) drain();
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_we        = 1'b0;
      csr_addr      = '0;
      csr_wdata     = '0;
      no_idle       = 1'b0;
      ticks_sent    = 0;
      settings_used = 0;
      idle_cycles   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      run_random();
      drain();
      repeat (4) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected states never arrived", sb.pending());
         sb.mismatches++;
      end

      $display("ran %0d control ticks under %0d register settings, all four run modes",
               ticks_sent, settings_used);
      $display("checked %0d relay results, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
